// ===== hw/rtl/qbps_pkg.sv =====
package qbps_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MIN_STEPS   = 6;
    localparam int MAX_STEPS   = 24;
    localparam int OFF_WIDTH   = 10;

    localparam int CW   = COORD_WIDTH;
    localparam int SW   = $clog2(MAX_STEPS + 1);
    localparam int DW   = $clog2(MAX_STEPS * MAX_STEPS + 1);
    localparam int CPW  = CW + 2;
    localparam int PW   = DW + CW + 3;
    localparam int NUMW = DW + CW + 2;
    localparam int D2W  = 2 * CW + 2;
    localparam int CNTW = $clog2(NUMW);
    localparam int QDEPTH = 2;
    localparam int PTRW   = $clog2(QDEPTH);

    // crossed limits: the upper one wins
    localparam int STEPS_LOW   = (MIN_STEPS > MAX_STEPS) ? MAX_STEPS : MIN_STEPS;
    localparam int STEP_PX     = 25;
    localparam int HOP_MIN_SQ  = 36;
    localparam logic [31:0] EASE_LOW_FRAC  = 32'd228923386;
    localparam logic [31:0] EASE_HIGH_FRAC = 32'd1346775048;
    localparam logic [2:0]  DLY_SNAP = 3'd0;

    typedef enum logic [2:0] {F_IDLE, F_SQR, F_SUM, F_CNT, F_PUSH} t_fstate;
    typedef enum logic [2:0] {B_IDLE, B_COEF, B_MUL, B_SUM, B_DIV, B_OUT, B_SNAP} t_bstate;

    typedef struct packed {
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [CW-1:0]  x2;
        logic signed [CW-1:0]  y2;
        logic signed [CPW-1:0] cx2;
        logic signed [CPW-1:0] cy2;
        logic [SW-1:0]         steps;
        logic                  hop;
    } t_cmd;

    function automatic logic [D2W-1:0] step_thr(input logic [SW:0] k);
        logic [D2W-1:0] kk;
        kk = D2W'(k) * D2W'(k);
        return kk * D2W'(STEP_PX * STEP_PX);
    endfunction

    function automatic logic [2:0] ease_delay(input logic [SW-1:0] i, input logic [SW-1:0] s);
        logic [SW-1:0]    f;
        logic [SW+31:0]   fs;
        logic [SW+31:0]   lo;
        logic [SW+31:0]   hi;
        f  = (i < SW'(s - i)) ? i : SW'(s - i);
        fs = {f, 32'd0};
        lo = (SW + 32)'(EASE_LOW_FRAC) * (SW + 32)'(s);
        hi = (SW + 32)'(EASE_HIGH_FRAC) * (SW + 32)'(s);
        if (fs < lo) begin
            return 3'd1;
        end else if ((SW + 3)'(f) * (SW + 3)'(6) < (SW + 3)'(s)) begin
            return 3'd2;
        end else if (fs < hi) begin
            return 3'd3;
        end
        return 3'd4;
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic neg,
                                                       input logic [NUMW-1:0] q);
        logic [NUMW-1:0] pos_max;
        logic [NUMW-1:0] neg_max;
        pos_max = NUMW'((64'd1 << (CW - 1)) - 64'd1);
        neg_max = NUMW'(64'd1 << (CW - 1));
        if (!neg) begin
            return (q > pos_max) ? CW'(pos_max) : CW'(q);
        end
        return (q > neg_max) ? CW'(neg_max) : CW'(~q + NUMW'(1));
    endfunction

endpackage

// ===== hw/rtl/qbps_if.sv =====
interface qbps_in_if;
    import qbps_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [CW-1:0]        start_x;
    logic signed [CW-1:0]        start_y;
    logic                        cursor_valid;
    logic signed [CW-1:0]        target_x;
    logic signed [CW-1:0]        target_y;
    logic signed [OFF_WIDTH-1:0] ctrl_offset_x;
    logic signed [OFF_WIDTH-1:0] ctrl_offset_y;

    modport source (output valid, start_x, start_y, cursor_valid, target_x, target_y,
                    ctrl_offset_x, ctrl_offset_y, input ready);
    modport sink (input valid, start_x, start_y, cursor_valid, target_x, target_y,
                  ctrl_offset_x, ctrl_offset_y, output ready);
endinterface

interface qbps_out_if;
    import qbps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic [2:0]           delay_ms;
    logic                 last;

    modport source (output valid, point_x, point_y, delay_ms, last, input ready);
    modport sink (input valid, point_x, point_y, delay_ms, last, output ready);
endinterface

// ===== hw/rtl/qbps_front.sv =====
module qbps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qbps_in_if.sink        i_in,
    output logic           o_push,
    output qbps_pkg::t_cmd o_cmd,
    input  logic           i_full
);
    import qbps_pkg::*;

    t_fstate r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    logic    r_cur, n_cur;
    logic signed [CW:0] r_dx, n_dx, r_dy, n_dy;
    logic [D2W-1:0] r_sqx, n_sqx, r_sqy, n_sqy, r_d2, n_d2;
    logic [SW-1:0]  r_s, n_s;
    logic signed [D2W-1:0] sqx_full, sqy_full;
    logic [SW:0]    k;
    logic [SW-1:0]  s_cl;

    assign sqx_full = D2W'(r_dx) * D2W'(r_dx);
    assign sqy_full = D2W'(r_dy) * D2W'(r_dy);
    assign k = (SW + 1)'(r_s) + (SW + 1)'(1);
    assign o_cmd = r_cmd;

    always_comb begin
        s_cl = r_s;
        if (r_s < SW'(STEPS_LOW)) begin
            s_cl = SW'(STEPS_LOW);
        end
        if (s_cl > SW'(MAX_STEPS)) begin
            s_cl = SW'(MAX_STEPS);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_cur = r_cur;
        n_dx = r_dx;
        n_dy = r_dy;
        n_sqx = r_sqx;
        n_sqy = r_sqy;
        n_d2 = r_d2;
        n_s = r_s;
        i_in.ready = 1'b0;
        o_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_cmd.x1 = i_in.start_x;
                    n_cmd.y1 = i_in.start_y;
                    n_cmd.x2 = i_in.target_x;
                    n_cmd.y2 = i_in.target_y;
                    n_cmd.cx2 = CPW'(i_in.start_x) + CPW'(i_in.target_x)
                              + CPW'($signed({i_in.ctrl_offset_x, 1'b0}));
                    n_cmd.cy2 = CPW'(i_in.start_y) + CPW'(i_in.target_y)
                              + CPW'($signed({i_in.ctrl_offset_y, 1'b0}));
                    n_cur = i_in.cursor_valid;
                    n_dx = (CW + 1)'(i_in.target_x) - (CW + 1)'(i_in.start_x);
                    n_dy = (CW + 1)'(i_in.target_y) - (CW + 1)'(i_in.start_y);
                    n_state = F_SQR;
                end
            end
            F_SQR: begin
                n_sqx = $unsigned(sqx_full);
                n_sqy = $unsigned(sqy_full);
                n_state = F_SUM;
            end
            F_SUM: begin
                n_d2 = r_sqx + r_sqy;
                n_s = '0;
                if (!r_cur || n_d2 < D2W'(HOP_MIN_SQ)) begin
                    n_cmd.hop = 1'b1;
                    n_cmd.steps = '0;
                    n_state = F_PUSH;
                end else begin
                    n_cmd.hop = 1'b0;
                    n_state = F_CNT;
                end
            end
            F_CNT: begin
                // count up while the next step length still fits the distance
                if (r_s < SW'(MAX_STEPS) && step_thr(k) <= r_d2) begin
                    n_s = SW'(k);
                end else begin
                    n_cmd.steps = s_cl;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_cur <= n_cur;
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_sqx <= n_sqx;
        r_sqy <= n_sqy;
        r_d2 <= n_d2;
        r_s <= n_s;
    end

endmodule

// ===== hw/rtl/qbps_queue.sv =====
module qbps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qbps_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output qbps_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import qbps_pkg::*;

    t_cmd r_mem [QDEPTH];
    logic [PTRW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [PTRW:0]   r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (PTRW + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTRW'(QDEPTH - 1)) ? '0 : r_wp + PTRW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PTRW'(QDEPTH - 1)) ? '0 : r_rp + PTRW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (PTRW + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (PTRW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/qbps_back.sv =====
module qbps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qbps_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    qbps_out_if.source     o_out
);
    import qbps_pkg::*;

    t_bstate r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    logic [SW-1:0] r_i, n_i;
    logic [DW-1:0] r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic [DW:0]   r_dv, n_dv;
    logic [2:0]    r_dly, n_dly;
    logic signed [PW-1:0] r_prod [2][3];
    logic signed [PW-1:0] n_prod [2][3];
    logic          r_neg [2];
    logic          n_neg [2];
    logic [DW:0]   r_rem [2];
    logic [DW:0]   n_rem [2];
    logic [NUMW-1:0] r_quo [2];
    logic [NUMW-1:0] n_quo [2];
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic          r_ov, n_ov;
    logic signed [CW-1:0] r_px, n_px, r_py, n_py;
    logic [2:0]    r_odly, n_odly;
    logic          r_last, n_last;

    logic signed [CPW-1:0] op0 [2];
    logic signed [CPW-1:0] op1 [2];
    logic signed [CPW-1:0] op2 [2];
    logic signed [PW-1:0]  nsum [2];
    logic [PW-1:0]         nmag [2];
    logic [DW+1:0]         trial [2];
    logic                  ge [2];
    logic [SW-1:0]         rest;
    logic                  slot_free;

    assign op0[0] = CPW'(r_cmd.x1);
    assign op0[1] = CPW'(r_cmd.y1);
    assign op1[0] = r_cmd.cx2;
    assign op1[1] = r_cmd.cy2;
    assign op2[0] = CPW'(r_cmd.x2);
    assign op2[1] = CPW'(r_cmd.y2);
    assign rest = r_cmd.steps - r_i;
    assign slot_free = !r_ov || o_out.ready;

    assign o_out.valid    = r_ov;
    assign o_out.point_x  = r_px;
    assign o_out.point_y  = r_py;
    assign o_out.delay_ms = r_odly;
    assign o_out.last     = r_last;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            nsum[l] = r_prod[l][0] + r_prod[l][1] + r_prod[l][2];
            nmag[l] = nsum[l][PW-1] ? $unsigned(-nsum[l]) : $unsigned(nsum[l]);
            trial[l] = {r_rem[l], r_quo[l][NUMW-1]};
            ge[l] = (trial[l] >= (DW + 2)'(r_dv));
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_i = r_i;
        n_ca = r_ca;
        n_cb = r_cb;
        n_cc = r_cc;
        n_dv = r_dv;
        n_dly = r_dly;
        n_prod = r_prod;
        n_neg = r_neg;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        n_px = r_px;
        n_py = r_py;
        n_odly = r_odly;
        n_last = r_last;
        n_ov = r_ov && !o_out.ready;
        o_pop = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_i = SW'(1);
                    n_state = i_cmd.hop ? B_SNAP : B_COEF;
                end
            end
            B_COEF: begin
                n_ca = DW'(rest) * DW'(rest);
                n_cb = DW'(r_i) * DW'(rest);
                n_cc = DW'(r_i) * DW'(r_i);
                n_dv = ((DW + 1)'(r_cmd.steps) * (DW + 1)'(r_cmd.steps)) << 1;
                n_dly = ease_delay(r_i, r_cmd.steps);
                n_state = B_MUL;
            end
            B_MUL: begin
                for (int l = 0; l < 2; l++) begin
                    n_prod[l][0] = PW'($signed({1'b0, r_ca})) * PW'(op0[l]);
                    n_prod[l][1] = PW'($signed({1'b0, r_cb})) * PW'(op1[l]);
                    n_prod[l][2] = PW'($signed({1'b0, r_cc})) * PW'(op2[l]);
                end
                n_state = B_SUM;
            end
            B_SUM: begin
                // round half away from zero: (2|N| + D) / 2D, sign put back after
                for (int l = 0; l < 2; l++) begin
                    n_neg[l] = nsum[l][PW-1];
                    n_quo[l] = NUMW'({nmag[l], 1'b0}) + NUMW'(r_dv >> 1);
                    n_rem[l] = '0;
                end
                n_cnt = CNTW'(NUMW - 1);
                n_state = B_DIV;
            end
            B_DIV: begin
                for (int l = 0; l < 2; l++) begin
                    n_rem[l] = ge[l] ? (DW + 1)'(trial[l] - (DW + 2)'(r_dv))
                                     : (DW + 1)'(trial[l]);
                    n_quo[l] = {r_quo[l][NUMW-2:0], ge[l]};
                end
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    n_px = sat_coord(r_neg[0], r_quo[0]);
                    n_py = sat_coord(r_neg[1], r_quo[1]);
                    n_odly = r_dly;
                    n_last = 1'b0;
                    if (r_i == r_cmd.steps) begin
                        n_state = B_SNAP;
                    end else begin
                        n_i = r_i + SW'(1);
                        n_state = B_COEF;
                    end
                end
            end
            B_SNAP: begin
                if (slot_free) begin
                    n_ov = 1'b1;
                    n_px = r_cmd.x2;
                    n_py = r_cmd.y2;
                    n_odly = DLY_SNAP;
                    n_last = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_i <= n_i;
        r_ca <= n_ca;
        r_cb <= n_cb;
        r_cc <= n_cc;
        r_dv <= n_dv;
        r_dly <= n_dly;
        r_prod <= n_prod;
        r_neg <= n_neg;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        r_px <= n_px;
        r_py <= n_py;
        r_odly <= n_odly;
        r_last <= n_last;
    end

endmodule

// ===== hw/rtl/quadratic_bezier_path_stepper.sv =====
// Quadratic Bezier cursor path stepper.
// i_in takes one move request (start, target, cursor_valid, control offset);
// o_out gives the path points, each with a delay_ms pause, and ends every
// request with a snap to the target that has last = 1 and delay_ms = 0.
// Both channels are valid/ready; an item moves when both are high.
// A front end squares the distance and counts the steps, one compare per
// cycle, then hands a command through a two-entry queue to the back end,
// so the next request is taken while the previous path is still drawn.
// Front end: a short hop or an unknown start skips the step count and goes
// straight to the push. Back end: each path point goes through the 28-step
// radix-2 divider that rounds both coordinates in parallel, and every
// request ends with the snap; a short hop or an unknown start gives the
// target alone, as the snap.
// When the receiver stalls the output register holds its point, the back
// end waits, and once the queue fills the front end stops taking requests.
// Reset empties the queue, drops any path in flight and clears o_out.valid.
module quadratic_bezier_path_stepper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qbps_in_if.sink    i_in,
    qbps_out_if.source o_out
);
    import qbps_pkg::*;

    logic push, full, pop, empty;
    t_cmd cmd_in, cmd_out;

    qbps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_cmd   (cmd_in),
        .i_full  (full)
    );

    qbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    qbps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/qbps_check.sv =====
module qbps_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [qbps_pkg::CW-1:0] i_point_x,
    input logic signed [qbps_pkg::CW-1:0] i_point_y,
    input logic [2:0]                     i_delay_ms,
    input logic                           i_last
);
    import qbps_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_point_x)
            && $stable(i_point_y) && $stable(i_delay_ms) && $stable(i_last))
        else $error("output item changed while stalled");

    a_snap_dly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> i_delay_ms == DLY_SNAP)
        else $error("snap item with nonzero delay");

    a_path_dly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_delay_ms >= 3'd1 && i_delay_ms <= 3'd4)
        else $error("path item delay out of range");

endmodule

bind quadratic_bezier_path_stepper qbps_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_point_x   (o_out.point_x),
    .i_point_y   (o_out.point_y),
    .i_delay_ms  (o_out.delay_ms),
    .i_last      (o_out.last)
);

// ===== dv/qbps_checker.sv =====
`timescale 1ns / 100ps
module qbps_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    qbps_in_if     i_in,
    qbps_out_if    i_out,
    output int     o_errors,
    output int     o_pending
);
    import qbps_pkg::*;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [2:0]           dly;
        logic                 last;
    } t_point;

    t_point path_q[$];
    int     errors;

    assign o_errors  = errors;
    assign o_pending = path_q.size();

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        if (v > hi) return CW'(hi);
        if (v < -hi - 1) return CW'(-hi - 1);
        return CW'(v);
    endfunction

    function automatic longint div_round(input longint n, input longint d);
        if (n >= 0) return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic logic [2:0] pause_for(input longint i, input longint s);
        longint f;
        f = (i < s - i) ? i : s - i;
        if ((f <<< 32) < longint'(EASE_LOW_FRAC) * s) return 3'd1;
        if (6 * f < s) return 3'd2;
        if ((f <<< 32) < longint'(EASE_HIGH_FRAC) * s) return 3'd3;
        return 3'd4;
    endfunction

    task automatic plan_path(input longint x1, y1, x2, y2, ox, oy, input logic ok);
        longint dx, dy, d2, cx2, cy2, s, a, b, c, d;
        t_point p;
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = dx * dx + dy * dy;
        cx2 = x1 + x2 + 2 * ox;
        cy2 = y1 + y2 + 2 * oy;
        if (ok && d2 >= HOP_MIN_SQ) begin
            s = 0;
            while (s < MAX_STEPS && 625 * (s + 1) * (s + 1) <= d2) s++;
            if (s < STEPS_LOW) s = STEPS_LOW;
            if (s > MAX_STEPS) s = MAX_STEPS;
            for (longint i = 1; i <= s; i++) begin
                a = (s - i) * (s - i);
                b = i * (s - i);
                c = i * i;
                d = s * s;
                p.px   = clamp_coord(div_round(a * x1 + b * cx2 + c * x2, d));
                p.py   = clamp_coord(div_round(a * y1 + b * cy2 + c * y2, d));
                p.dly  = pause_for(i, s);
                p.last = 1'b0;
                path_q.push_back(p);
            end
        end
        p.px   = CW'(x2);
        p.py   = CW'(y2);
        p.dly  = DLY_SNAP;
        p.last = 1'b1;
        path_q.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            errors <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                plan_path(i_in.start_x, i_in.start_y, i_in.target_x, i_in.target_y,
                          i_in.ctrl_offset_x, i_in.ctrl_offset_y, i_in.cursor_valid);
            if (i_out.valid && i_out.ready) begin
                if (path_q.size() == 0) begin
                    $display("%0t: unexpected item x=%0d y=%0d dly=%0d last=%0b", $time,
                             i_out.point_x, i_out.point_y, i_out.delay_ms, i_out.last);
                    errors <= errors + 1;
                end else begin
                    e = path_q.pop_front();
                    if (e.px !== i_out.point_x || e.py !== i_out.point_y ||
                        e.dly !== i_out.delay_ms || e.last !== i_out.last) begin
                        $display("%0t: expected x=%0d y=%0d dly=%0d last=%0b, got x=%0d y=%0d dly=%0d last=%0b",
                                 $time, e.px, e.py, e.dly, e.last, i_out.point_x,
                                 i_out.point_y, i_out.delay_ms, i_out.last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_quadratic_bezier_path_stepper.sv =====
`timescale 1ns / 100ps
module tb_quadratic_bezier_path_stepper;
    import qbps_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;

    qbps_in_if  move_if ();
    qbps_out_if path_if ();

    quadratic_bezier_path_stepper u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (move_if.sink),
        .o_out  (path_if.source)
    );

    qbps_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (move_if),
        .i_out    (path_if),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        move_if.valid = 1'b0;
        move_if.start_x = '0;
        move_if.start_y = '0;
        move_if.cursor_valid = 1'b0;
        move_if.target_x = '0;
        move_if.target_y = '0;
        move_if.ctrl_offset_x = '0;
        move_if.ctrl_offset_y = '0;
        path_if.ready = 1'b0;
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off)
                path_if.ready <= 1'b0;
            else if ((phase / 400) % 3 == 0)
                path_if.ready <= 1'b1;
            else
                path_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (move_if.valid && move_if.ready) || (path_if.valid && path_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_move(input logic [CW-1:0] sx, sy, tx, ty,
                             input logic ok, input logic [OFF_WIDTH-1:0] ox, oy);
        move_if.valid         <= 1'b1;
        move_if.start_x       <= sx;
        move_if.start_y       <= sy;
        move_if.cursor_valid  <= ok;
        move_if.target_x      <= tx;
        move_if.target_y      <= ty;
        move_if.ctrl_offset_x <= ox;
        move_if.ctrl_offset_y <= oy;
        do @(posedge i_clk); while (!move_if.ready);
    endtask

    task automatic rest(input int n);
        move_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] near(input logic [CW-1:0] base, input int span);
        return base + CW'($urandom_range(0, 2 * span) - span);
    endfunction

    task automatic send_random();
        logic [CW-1:0] sx, sy;
        int kind, span;
        sx = CW'($urandom);
        sy = CW'($urandom);
        kind = $urandom_range(0, 9);
        span = (kind < 6) ? $urandom_range(10, 400) : 700;
        if (kind == 9)
            send_move(sx, sy, CW'($urandom), CW'($urandom), 1'($urandom),
                      OFF_WIDTH'($urandom), OFF_WIDTH'($urandom));
        else if (kind == 8)
            send_move(sx, sy, near(sx, 5), near(sy, 5), 1'b1,
                      OFF_WIDTH'($urandom), OFF_WIDTH'($urandom));
        else
            send_move(sx, sy, near(sx, span), near(sy, span), kind != 7,
                      OFF_WIDTH'($urandom), OFF_WIDTH'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: unknown start, short hops, step extremes, saturation
        send_move(16'd0, 16'd0, 16'd500, 16'd500, 1'b0, 10'd0, 10'd0);
        send_move(16'd0, 16'd0, 16'd5, 16'd0, 1'b1, 10'd0, 10'd0);
        send_move(16'd0, 16'd0, 16'd6, 16'd0, 1'b1, 10'd0, 10'd0);
        send_move(16'd0, 16'd0, 16'd3, 16'd5, 1'b1, 10'h1FF, 10'h200);
        send_move(16'd100, 16'd100, 16'd250, 16'd100, 1'b1, 10'd5, 10'h3FB);
        send_move(16'd0, 16'd0, 16'd175, 16'd0, 1'b1, 10'd0, 10'd0);
        send_move(16'd0, 16'd0, 16'd600, 16'd0, 1'b1, 10'd0, 10'd0);
        send_move(16'd0, 16'd0, 16'd625, 16'd0, 1'b1, 10'd0, 10'd0);
        send_move(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 10'h1FF, 10'h1FF);
        send_move(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 10'h200, 10'h200);
        send_move(16'h7F00, 16'h7F00, 16'h7FFF, 16'h7FFF, 1'b1, 10'h1FF, 10'h1FF);
        send_move(16'h8100, 16'h8000, 16'h8000, 16'h8100, 1'b1, 10'h200, 10'h200);
        send_move(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 10'h3FF, 10'h3FF);
        send_move(16'h1234, 16'h8765, 16'h0FF0, 16'h8888, 1'b1, 10'h155, 10'h2AA);
        rest(1);
        // pressure: long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6) send_random();
        join
        rest(1);
        // pause until every expected item is out
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 130; n++) begin
            if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 60));
            send_random();
        end
        rest(1);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (900) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
